>>> hw/rtl/sccr_pkg.sv
// ----------------------------------------------------------------------------
// sccr_pkg: shared types and constants for the swept circle collider
// Field widths, bus widths, the per-item context record and saturation.
// ----------------------------------------------------------------------------
package sccr_pkg;

	localparam int W_POS  = 32;
	localparam int W_RAD  = 31;
	localparam int W_NRM  = 18;
	localparam int W_S_TDATA = 328;
	localparam int W_M_TDATA = 160;

	localparam int NUM_DIV_STAGES = 16;

	localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] T_ONE   = 32'sh0001_0000;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [17:0] nx;
		logic signed [17:0] ny;
		logic signed [32:0] vx;
		logic signed [32:0] vy;
	} ctx_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'(SAT_MAX)) begin
			return SAT_MAX;
		end else if (v < 64'(SAT_MIN)) begin
			return SAT_MIN;
		end
		return v[31:0];
	endfunction

endpackage

>>> hw/rtl/swept_circle_segment_collide_reflect_top.sv
// ----------------------------------------------------------------------------
// swept_circle_segment_collide_reflect_top: swept circle vs segment collider
// Hit time, contact centre and reflected end point for a moving circle.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* takes one query item per accepted beat: start, end,
//   radius, segment ends and unit normal packed in s_tdata. Master channel
//   m_* returns one result item per query, in order: hit flag in m_tuser,
//   hit time, contact centre and reflected end point in m_tdata. A miss
//   returns m_tuser low and m_tdata all zero.
//   Throughput is one item per cycle while m_tready is high. Six stages
//   form distances and the time quotient operands, sixteen stages run
//   the restoring divider two quotient bits per stage, and eight stages
//   form the contact point, the end-of-segment tests and the reflection.
//   Reset clears all stage valid bits; the pipeline comes up empty and
//   ready. When m_tready is low, the item on the output holds and each
//   stage accepts as long as it or some stage ahead of it is empty, so
//   bubbles close up and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module swept_circle_segment_collide_reflect_top import sccr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// start_x, start_y, end_x, end_y, radius, seg_a_x, seg_a_y, seg_b_x,
	// seg_b_y, normal_x, normal_y, zero pad
	input  logic [W_S_TDATA-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// hit_time, hit_x, hit_y, reflect_x, reflect_y
	output logic [W_M_TDATA-1:0] m_tdata,
	// hit
	output logic                 m_tuser
);

	localparam int NS    = 30;
	localparam int ST_DV = 6;

	logic [NS:1]   vld_q;
	logic [NS+1:1] en;

	always_comb begin
		en[NS+1] = m_tready;
		for (int k = NS; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stage 1: unpack, differences
	ctx_t               ctx_s1;
	logic [30:0]        rq_s1;
	logic signed [32:0] dsx_s1, dsy_s1, dex_s1, dey_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ctx_s1.sx <= s_tdata[31:0];
			ctx_s1.sy <= s_tdata[63:32];
			ctx_s1.ex <= s_tdata[95:64];
			ctx_s1.ey <= s_tdata[127:96];
			ctx_s1.ax <= s_tdata[190:159];
			ctx_s1.ay <= s_tdata[222:191];
			ctx_s1.bx <= s_tdata[254:223];
			ctx_s1.by <= s_tdata[286:255];
			ctx_s1.nx <= s_tdata[304:287];
			ctx_s1.ny <= s_tdata[322:305];
			ctx_s1.vx <= 33'($signed(s_tdata[95:64])) - 33'($signed(s_tdata[31:0]));
			ctx_s1.vy <= 33'($signed(s_tdata[127:96])) - 33'($signed(s_tdata[63:32]));
			rq_s1     <= s_tdata[158:128];
			dsx_s1    <= 33'($signed(s_tdata[31:0])) - 33'($signed(s_tdata[190:159]));
			dsy_s1    <= 33'($signed(s_tdata[63:32])) - 33'($signed(s_tdata[222:191]));
			dex_s1    <= 33'($signed(s_tdata[95:64])) - 33'($signed(s_tdata[190:159]));
			dey_s1    <= 33'($signed(s_tdata[127:96])) - 33'($signed(s_tdata[222:191]));
		end
	end

	// stage 2: normal products
	ctx_t               ctx_s2;
	logic [30:0]        rq_s2;
	logic signed [50:0] psx_s2, psy_s2, pex_s2, pey_s2, pvx_s2, pvy_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ctx_s2 <= ctx_s1;
			rq_s2  <= rq_s1;
			psx_s2 <= ctx_s1.nx * dsx_s1;
			psy_s2 <= ctx_s1.ny * dsy_s1;
			pex_s2 <= ctx_s1.nx * dex_s1;
			pey_s2 <= ctx_s1.ny * dey_s1;
			pvx_s2 <= ctx_s1.nx * ctx_s1.vx;
			pvy_s2 <= ctx_s1.ny * ctx_s1.vy;
		end
	end

	// stage 3: distances and denominator
	ctx_t               ctx_s3;
	logic [30:0]        rq_s3;
	logic signed [51:0] ds_s3, de_s3, den_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ctx_s3 <= ctx_s2;
			rq_s3  <= rq_s2;
			ds_s3  <= 52'(psx_s2) + 52'(psy_s2);
			de_s3  <= 52'(pex_s2) + 52'(pey_s2);
			den_s3 <= 52'(pvx_s2) + 52'(pvy_s2);
		end
	end

	// stage 4: band and parallel rejects, numerator
	ctx_t               ctx_s4;
	logic               miss_s4;
	logic signed [53:0] num_s4;
	logic signed [51:0] den_s4;
	logic signed [51:0] rqw;

	assign rqw = $signed({5'd0, rq_s3, 16'd0});

	always_ff @(posedge clk) begin
		if (en[4]) begin
			ctx_s4  <= ctx_s3;
			den_s4  <= den_s3;
			miss_s4 <= (den_s3 == '0) || (ds_s3 < -rqw && de_s3 < -rqw) ||
				(ds_s3 > rqw && de_s3 > rqw);
			num_s4  <= (ds_s3[51] ? -54'(rqw) : 54'(rqw)) - 54'(ds_s3);
		end
	end

	// stage 5: magnitudes and quotient sign
	ctx_t        ctx_s5;
	logic        miss_s5, neg_s5;
	logic [52:0] un_s5;
	logic [51:0] ud_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			ctx_s5  <= ctx_s4;
			miss_s5 <= miss_s4;
			neg_s5  <= num_s4[53] ^ den_s4[51];
			un_s5   <= num_s4[53] ? 53'(-num_s4) : num_s4[52:0];
			ud_s5   <= den_s4[51] ? 52'(-den_s4) : den_s4;
		end
	end

	// stage 6 (index 0) and divider stages 7..22 (index 1..16)
	ctx_t        div_ctx_s  [NUM_DIV_STAGES+1];
	logic        div_miss_s [NUM_DIV_STAGES+1];
	logic        div_neg_s  [NUM_DIV_STAGES+1];
	logic        div_ovf_s  [NUM_DIV_STAGES+1];
	logic [51:0] div_ud_s   [NUM_DIV_STAGES+1];
	logic [51:0] div_rem_s  [NUM_DIV_STAGES+1];
	logic [31:0] div_sh_s   [NUM_DIV_STAGES+1];
	logic [31:0] div_q_s    [NUM_DIV_STAGES+1];

	logic [51:0] dv_rem_n [NUM_DIV_STAGES];
	logic [31:0] dv_sh_n  [NUM_DIV_STAGES];
	logic [31:0] dv_q_n   [NUM_DIV_STAGES];

	always_comb begin
		logic [52:0] r2;
		logic [51:0] r;
		logic [31:0] sh, q;
		for (int j = 0; j < NUM_DIV_STAGES; j++) begin
			r  = div_rem_s[j];
			sh = div_sh_s[j];
			q  = div_q_s[j];
			for (int b = 0; b < 2; b++) begin
				r2 = {r, sh[31]};
				sh = {sh[30:0], 1'b0};
				if (r2 >= {1'b0, div_ud_s[j]}) begin
					r2 = r2 - {1'b0, div_ud_s[j]};
					q  = {q[30:0], 1'b1};
				end else begin
					q  = {q[30:0], 1'b0};
				end
				r = r2[51:0];
			end
			dv_rem_n[j] = r;
			dv_sh_n[j]  = sh;
			dv_q_n[j]   = q;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_DV]) begin
			div_ctx_s[0]  <= ctx_s5;
			div_miss_s[0] <= miss_s5 || (!neg_s5 && un_s5 > {1'b0, ud_s5});
			div_neg_s[0]  <= neg_s5;
			div_ovf_s[0]  <= {15'd0, un_s5[52:16]} >= ud_s5;
			div_ud_s[0]   <= ud_s5;
			div_rem_s[0]  <= {15'd0, un_s5[52:16]};
			div_sh_s[0]   <= {un_s5[15:0], 16'd0};
			div_q_s[0]    <= '0;
		end
		for (int j = 0; j < NUM_DIV_STAGES; j++) begin
			if (en[ST_DV+1+j]) begin
				div_ctx_s[j+1]  <= div_ctx_s[j];
				div_miss_s[j+1] <= div_miss_s[j];
				div_neg_s[j+1]  <= div_neg_s[j];
				div_ovf_s[j+1]  <= div_ovf_s[j];
				div_ud_s[j+1]   <= div_ud_s[j];
				div_rem_s[j+1]  <= dv_rem_n[j];
				div_sh_s[j+1]   <= dv_sh_n[j];
				div_q_s[j+1]    <= dv_q_n[j];
			end
		end
	end

	// stage 23: signed, saturated hit time
	ctx_t               ctx_s23;
	logic               miss_s23;
	logic signed [31:0] tq_s23;
	logic [31:0]        qf;

	assign qf = div_q_s[NUM_DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en[23]) begin
			ctx_s23  <= div_ctx_s[NUM_DIV_STAGES];
			miss_s23 <= div_miss_s[NUM_DIV_STAGES];
			if (!div_neg_s[NUM_DIV_STAGES]) begin
				tq_s23 <= $signed(qf);
			end else if (div_ovf_s[NUM_DIV_STAGES] || qf[31]) begin
				tq_s23 <= SAT_MIN;
			end else begin
				tq_s23 <= -$signed(qf);
			end
		end
	end

	// stage 24: motion times hit time
	ctx_t               ctx_s24;
	logic               miss_s24;
	logic signed [31:0] tq_s24;
	logic signed [64:0] mvx_s24, mvy_s24;

	always_ff @(posedge clk) begin
		if (en[24]) begin
			ctx_s24  <= ctx_s23;
			miss_s24 <= miss_s23;
			tq_s24   <= tq_s23;
			mvx_s24  <= ctx_s23.vx * tq_s23;
			mvy_s24  <= ctx_s23.vy * tq_s23;
		end
	end

	// stage 25: contact centre
	ctx_t               ctx_s25;
	logic               miss_s25;
	logic signed [31:0] tq_s25, hxs_s25, hys_s25;
	logic signed [49:0] hx_s25, hy_s25;
	logic signed [65:0] hsx, hsy;
	logic signed [49:0] hxn, hyn;

	assign hsx = $signed({{18{ctx_s24.sx[31]}}, ctx_s24.sx, 16'd0}) + 66'(mvx_s24);
	assign hsy = $signed({{18{ctx_s24.sy[31]}}, ctx_s24.sy, 16'd0}) + 66'(mvy_s24);
	assign hxn = hsx[65:16];
	assign hyn = hsy[65:16];

	always_ff @(posedge clk) begin
		if (en[25]) begin
			ctx_s25  <= ctx_s24;
			miss_s25 <= miss_s24;
			tq_s25   <= tq_s24;
			hx_s25   <= hxn;
			hy_s25   <= hyn;
			hxs_s25  <= sat32(64'(hxn));
			hys_s25  <= sat32(64'(hyn));
		end
	end

	// stage 26: offsets from segment ends and from the end point
	ctx_t               ctx_s26;
	logic               miss_s26;
	logic signed [31:0] tq_s26, hxs_s26, hys_s26;
	logic signed [50:0] dxb_s26, dyb_s26, dxa_s26, dya_s26;
	logic signed [32:0] abx_s26, aby_s26, ix_s26, iy_s26;

	always_ff @(posedge clk) begin
		if (en[26]) begin
			ctx_s26  <= ctx_s25;
			miss_s26 <= miss_s25;
			tq_s26   <= tq_s25;
			hxs_s26  <= hxs_s25;
			hys_s26  <= hys_s25;
			dxb_s26  <= 51'(hx_s25) - 51'(ctx_s25.bx);
			dyb_s26  <= 51'(hy_s25) - 51'(ctx_s25.by);
			dxa_s26  <= 51'(hx_s25) - 51'(ctx_s25.ax);
			dya_s26  <= 51'(hy_s25) - 51'(ctx_s25.ay);
			abx_s26  <= 33'(ctx_s25.ax) - 33'(ctx_s25.bx);
			aby_s26  <= 33'(ctx_s25.ay) - 33'(ctx_s25.by);
			ix_s26   <= 33'(ctx_s25.ex) - 33'(hxs_s25);
			iy_s26   <= 33'(ctx_s25.ey) - 33'(hys_s25);
		end
	end

	// stage 27: partial products for end tests, normal projection of E - H
	ctx_t               ctx_s27;
	logic               miss_s27;
	logic signed [31:0] tq_s27, hxs_s27, hys_s27;
	logic signed [59:0] lbx_s27, lby_s27, lax_s27, lay_s27;
	logic signed [57:0] hbx_s27, hby_s27, hax_s27, hay_s27;
	logic signed [50:0] dnx_s27, dny_s27;

	always_ff @(posedge clk) begin
		if (en[27]) begin
			ctx_s27  <= ctx_s26;
			miss_s27 <= miss_s26;
			tq_s27   <= tq_s26;
			hxs_s27  <= hxs_s26;
			hys_s27  <= hys_s26;
			lbx_s27  <= $signed({1'b0, dxb_s26[25:0]}) * abx_s26;
			lby_s27  <= $signed({1'b0, dyb_s26[25:0]}) * aby_s26;
			lax_s27  <= $signed({1'b0, dxa_s26[25:0]}) * abx_s26;
			lay_s27  <= $signed({1'b0, dya_s26[25:0]}) * aby_s26;
			hbx_s27  <= $signed(dxb_s26[50:26]) * abx_s26;
			hby_s27  <= $signed(dyb_s26[50:26]) * aby_s26;
			hax_s27  <= $signed(dxa_s26[50:26]) * abx_s26;
			hay_s27  <= $signed(dya_s26[50:26]) * aby_s26;
			dnx_s27  <= ctx_s26.nx * ix_s26;
			dny_s27  <= ctx_s26.ny * iy_s26;
		end
	end

	// stage 28: per-axis products
	ctx_t               ctx_s28;
	logic               miss_s28;
	logic signed [31:0] tq_s28, hxs_s28, hys_s28;
	logic signed [84:0] pbx_s28, pby_s28, pax_s28, pay_s28;
	logic signed [51:0] dn_s28;

	always_ff @(posedge clk) begin
		if (en[28]) begin
			ctx_s28  <= ctx_s27;
			miss_s28 <= miss_s27;
			tq_s28   <= tq_s27;
			hxs_s28  <= hxs_s27;
			hys_s28  <= hys_s27;
			pbx_s28  <= (85'(hbx_s27) <<< 26) + 85'(lbx_s27);
			pby_s28  <= (85'(hby_s27) <<< 26) + 85'(lby_s27);
			pax_s28  <= (85'(hax_s27) <<< 26) + 85'(lax_s27);
			pay_s28  <= (85'(hay_s27) <<< 26) + 85'(lay_s27);
			dn_s28   <= 52'(dnx_s27) + 52'(dny_s27);
		end
	end

	// stage 29: end tests, reflection products
	ctx_t               ctx_s29;
	logic               miss_s29;
	logic signed [31:0] tq_s29, hxs_s29, hys_s29;
	logic signed [69:0] rx_s29, ry_s29;
	logic signed [85:0] dotb, dota;

	assign dotb = 86'(pbx_s28) + 86'(pby_s28);
	assign dota = 86'(pax_s28) + 86'(pay_s28);

	always_ff @(posedge clk) begin
		if (en[29]) begin
			ctx_s29  <= ctx_s28;
			miss_s29 <= miss_s28 || dotb[85] || (dota > 86'sd0);
			tq_s29   <= tq_s28;
			hxs_s29  <= hxs_s28;
			hys_s29  <= hys_s28;
			rx_s29   <= dn_s28 * ctx_s28.nx;
			ry_s29   <= dn_s28 * ctx_s28.ny;
		end
	end

	// stage 30: reflected end point, output register
	logic                 hit_s30;
	logic [W_M_TDATA-1:0] data_s30;
	logic signed [39:0]   rfx, rfy;

	assign rfx = 40'(ctx_s29.ex) - 40'($signed(rx_s29[69:31]));
	assign rfy = 40'(ctx_s29.ey) - 40'($signed(ry_s29[69:31]));

	always_ff @(posedge clk) begin
		if (en[30]) begin
			hit_s30 <= !miss_s29;
			if (miss_s29) begin
				data_s30 <= '0;
			end else begin
				data_s30 <= {sat32(64'(rfy)), sat32(64'(rfx)), hys_s29, hxs_s29, tq_s29};
			end
		end
	end

	assign m_tdata = data_s30;
	assign m_tuser = hit_s30;

endmodule

>>> hw/rtl/sccr_check.sv
// ----------------------------------------------------------------------------
// sccr_check: port-level checks for the swept circle collider
// Output hold under stall, miss encoding, hit time bound, ready with empty output.
// ----------------------------------------------------------------------------
module sccr_check import sccr_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [W_M_TDATA-1:0] m_tdata,
	input logic                 m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result item changed");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss item carries nonzero data");

	a_time_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> $signed(m_tdata[31:0]) <= T_ONE)
		else $error("hit time above one");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind swept_circle_segment_collide_reflect_top sccr_check u_sccr_check (.*);
